FILE: rtl/keyed_symbol_table_macros.svh
// ---------------------------------------------------------------------------
// keyed symbol table assertion macros
// shared property wrappers for the checker
// ---------------------------------------------------------------------------
`ifndef KEYED_SYMBOL_TABLE_MACROS_SVH
`define KEYED_SYMBOL_TABLE_MACROS_SVH

// checked only outside reset
`define KST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define KST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/kst_pkg.sv
// ---------------------------------------------------------------------------
// kst_pkg
// types, codes and sizes shared by the keyed symbol table
// ---------------------------------------------------------------------------
package kst_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int NAME_WORDS  = 4;
  localparam int WORD_W      = 64;
  localparam int NAME_W      = NAME_WORDS * WORD_W;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int SIZE_W      = 16;
  localparam int KIND_W      = 3;
  localparam int OP_W        = 4;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [NAME_W-1:0] name_t;

  typedef enum logic [OP_W-1:0] {
    OP_DECL_VAR   = 4'd0,
    OP_DECL_CONST = 4'd1,
    OP_CHECK      = 4'd2,
    OP_INDEX      = 4'd3,
    OP_INDEX_ANY  = 4'd4,
    OP_DIVISOR    = 4'd5,
    OP_READ       = 4'd6,
    OP_ASSIGN     = 4'd7,
    OP_CLEAR      = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_REDECLARED    = 3'd1,
    ST_FULL          = 3'd2,
    ST_UNDECLARED    = 3'd3,
    ST_NOT_ARRAY     = 3'd4,
    ST_OUT_OF_RANGE  = 3'd5,
    ST_ZERO_DIVISOR  = 3'd6,
    ST_UNDECL_ASSIGN = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FETCH,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    name_t             name;
    logic [KIND_W-1:0] kind;
    logic [SIZE_W-1:0] size;
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] index;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              is_const;
    logic [SIZE_W-1:0] size;
    logic [DATA_W-1:0] const_val;
    logic [DATA_W-1:0] cur_val;
    logic              known;
  } attr_t;

  typedef struct packed {
    status_t           status;
    logic              known;
    logic [DATA_W-1:0] value;
  } res_t;

  typedef struct packed {
    logic start;
    logic wr_en;
    idx_t wr_addr;
  } srch_ctl_t;

  typedef struct packed {
    logic done;
    logic hit;
    idx_t idx;
  } srch_sts_t;

  function automatic name_t pack_name(input logic [WORD_W-1:0] w0,
                                      input logic [WORD_W-1:0] w1,
                                      input logic [WORD_W-1:0] w2,
                                      input logic [WORD_W-1:0] w3);
    logic [4*WORD_W-1:0] all_words;
    all_words = {w3, w2, w1, w0};
    return all_words[NAME_W-1:0];
  endfunction

endpackage

FILE: rtl/kst_if.sv
// ---------------------------------------------------------------------------
// kst channel interfaces
// valid/ready channels for operation items and result items
// ---------------------------------------------------------------------------
interface kst_in_if;
  logic                                      valid;
  logic                                      ready;
  logic [kst_pkg::OP_W-1:0]                  op;
  logic [kst_pkg::WORD_W-1:0]                name_word_0;
  logic [kst_pkg::WORD_W-1:0]                name_word_1;
  logic [kst_pkg::WORD_W-1:0]                name_word_2;
  logic [kst_pkg::WORD_W-1:0]                name_word_3;
  logic [kst_pkg::KIND_W-1:0]                var_kind;
  logic [kst_pkg::SIZE_W-1:0]                array_size;
  logic signed [kst_pkg::DATA_W-1:0]         data_value;
  logic signed [kst_pkg::DATA_W-1:0]         array_index;

  modport source (
    output valid, op, name_word_0, name_word_1, name_word_2, name_word_3,
           var_kind, array_size, data_value, array_index,
    input  ready
  );
  modport sink (
    input  valid, op, name_word_0, name_word_1, name_word_2, name_word_3,
           var_kind, array_size, data_value, array_index,
    output ready
  );
endinterface

interface kst_out_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        status;
  logic                              value_known;
  logic signed [kst_pkg::DATA_W-1:0] read_value;

  modport source (
    output valid, status, value_known, read_value,
    input  ready
  );
  modport sink (
    input  valid, status, value_known, read_value,
    output ready
  );
endinterface

FILE: rtl/kst_search.sv
// ---------------------------------------------------------------------------
// kst_search
// name memory and the single comparator that scans it one entry a cycle
// ---------------------------------------------------------------------------
module kst_search (
  input  logic               clk,
  input  logic               rst,
  input  kst_pkg::srch_ctl_t ctl,
  input  kst_pkg::name_t     key,
  input  kst_pkg::cnt_t      count,
  output kst_pkg::srch_sts_t sts
);

  kst_pkg::name_t mem [kst_pkg::TABLE_DEPTH];
  kst_pkg::name_t rd_data;
  kst_pkg::cnt_t  rd_addr;
  kst_pkg::idx_t  cmp_idx;
  logic           busy;
  logic           cmp_valid;
  logic           rd_go;
  logic           key_eq;
  logic           last_cmp;
  logic           stop;

  assign rd_go    = busy && (rd_addr < count);
  assign key_eq   = (rd_data == key);
  assign last_cmp = ((kst_pkg::cnt_t'(cmp_idx) + kst_pkg::cnt_t'(1)) == count);
  // stop on the first match or after the last live entry
  assign stop     = busy && cmp_valid && (key_eq || last_cmp);

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= key;
    end
    if (rd_go) begin
      rd_data <= mem[rd_addr[kst_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cmp_valid <= 1'b0;
      sts.done  <= 1'b0;
    end else begin
      sts.done <= (ctl.start && (count == '0)) || stop;
      if (ctl.start) begin
        busy      <= (count != '0);
        rd_addr   <= '0;
        cmp_valid <= 1'b0;
        if (count == '0) begin
          sts.hit <= 1'b0;
        end
      end else if (busy) begin
        busy      <= !stop;
        cmp_valid <= rd_go && !stop;
        cmp_idx   <= rd_addr[kst_pkg::IDX_W-1:0];
        if (rd_go) begin
          rd_addr <= rd_addr + kst_pkg::cnt_t'(1);
        end
        if (stop) begin
          sts.hit <= key_eq;
          sts.idx <= cmp_idx;
        end
      end
    end
  end

endmodule

FILE: rtl/kst_attr_store.sv
// ---------------------------------------------------------------------------
// kst_attr_store
// per-entry attribute memory with one write and one registered read
// ---------------------------------------------------------------------------
module kst_attr_store (
  input  logic           clk,
  input  logic           we,
  input  kst_pkg::idx_t  waddr,
  input  kst_pkg::attr_t wdata,
  input  kst_pkg::idx_t  raddr,
  output kst_pkg::attr_t rdata
);

  kst_pkg::attr_t mem [kst_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/kst_ctrl.sv
// ---------------------------------------------------------------------------
// kst_ctrl
// sequencer: search, attribute fetch, then result and table update
// ---------------------------------------------------------------------------
module kst_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_fire,
  input  logic               out_free,
  input  kst_pkg::item_t     item,
  input  kst_pkg::srch_sts_t sts,
  input  kst_pkg::attr_t     attr,
  output logic               idle,
  output kst_pkg::srch_ctl_t sctl,
  output kst_pkg::cnt_t      count,
  output logic               attr_we,
  output kst_pkg::idx_t      attr_waddr,
  output kst_pkg::attr_t     attr_wdata,
  output logic               out_load,
  output kst_pkg::res_t      res
);

  kst_pkg::state_t state;
  kst_pkg::state_t state_next;
  kst_pkg::cnt_t   entry_count;
  logic            full;
  logic            out_of_range;
  logic            decl_ok;
  logic            asgn_ok;
  logic            clr;

  assign count        = entry_count;
  assign full         = (entry_count >= kst_pkg::cnt_t'(kst_pkg::TABLE_DEPTH));
  // negative index, or not below the declared length
  assign out_of_range = item.index[kst_pkg::DATA_W-1] ||
                        (item.index[kst_pkg::DATA_W-2:0] >=
                         {{(kst_pkg::DATA_W-1-kst_pkg::SIZE_W){1'b0}}, attr.size});

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= kst_pkg::S_IDLE;
      entry_count <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        if (clr) begin
          entry_count <= '0;
        end else if (decl_ok) begin
          entry_count <= entry_count + kst_pkg::cnt_t'(1);
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kst_pkg::S_IDLE:   if (cmd_fire) state_next = kst_pkg::S_SEARCH;
      kst_pkg::S_SEARCH: if (sts.done) state_next = kst_pkg::S_FETCH;
      kst_pkg::S_FETCH:  state_next = kst_pkg::S_EXEC;
      kst_pkg::S_EXEC:   if (out_free) state_next = kst_pkg::S_IDLE;
    endcase
  end

  // operation decode, valid once the search and attribute fetch are done
  always_comb begin
    res        = '{status: kst_pkg::ST_OK, known: 1'b0, value: '0};
    decl_ok    = 1'b0;
    asgn_ok    = 1'b0;
    clr        = 1'b0;
    attr_wdata = attr;
    unique case (kst_pkg::op_t'(item.op))
      kst_pkg::OP_DECL_VAR, kst_pkg::OP_DECL_CONST: begin
        if (sts.hit) begin
          res.status = kst_pkg::ST_REDECLARED;
        end else if (full) begin
          res.status = kst_pkg::ST_FULL;
        end else begin
          decl_ok = 1'b1;
        end
        if (kst_pkg::op_t'(item.op) == kst_pkg::OP_DECL_VAR) begin
          attr_wdata = '{kind: item.kind, is_const: 1'b0, size: item.size,
                         const_val: '0, cur_val: '0, known: 1'b0};
        end else begin
          attr_wdata = '{kind: '0, is_const: 1'b1, size: '0,
                         const_val: item.data, cur_val: item.data, known: 1'b1};
        end
      end
      kst_pkg::OP_CHECK: begin
        if (!sts.hit) res.status = kst_pkg::ST_UNDECLARED;
      end
      kst_pkg::OP_INDEX, kst_pkg::OP_INDEX_ANY: begin
        if (!sts.hit) begin
          res.status = kst_pkg::ST_UNDECLARED;
        end else if (attr.size == '0) begin
          res.status = kst_pkg::ST_NOT_ARRAY;
        end else if ((kst_pkg::op_t'(item.op) == kst_pkg::OP_INDEX) && out_of_range) begin
          res.status = kst_pkg::ST_OUT_OF_RANGE;
        end
      end
      kst_pkg::OP_DIVISOR: begin
        if (item.data == '0) res.status = kst_pkg::ST_ZERO_DIVISOR;
      end
      kst_pkg::OP_READ: begin
        if (sts.hit) begin
          // a constant always reads back its declared value
          if (attr.is_const) begin
            res.known = 1'b1;
            res.value = attr.const_val;
          end else if (attr.known) begin
            res.known = 1'b1;
            res.value = attr.cur_val;
          end
        end
      end
      kst_pkg::OP_ASSIGN: begin
        if (!sts.hit) begin
          res.status = kst_pkg::ST_UNDECL_ASSIGN;
        end else begin
          asgn_ok            = 1'b1;
          attr_wdata.cur_val = item.data;
          attr_wdata.known   = 1'b1;
        end
      end
      kst_pkg::OP_CLEAR: begin
        clr = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    idle         = (state == kst_pkg::S_IDLE);
    out_load     = (state == kst_pkg::S_EXEC) && out_free;
    sctl.start   = idle && cmd_fire;
    sctl.wr_en   = out_load && decl_ok;
    sctl.wr_addr = entry_count[kst_pkg::IDX_W-1:0];
    attr_we      = out_load && (decl_ok || asgn_ok);
    attr_waddr   = decl_ok ? entry_count[kst_pkg::IDX_W-1:0] : sts.idx;
  end

endmodule

FILE: rtl/keyed_symbol_table.sv
// ---------------------------------------------------------------------------
// keyed_symbol_table
// Symbol table keyed by zero-padded names of up to 32 characters, holding
// up to 64 entries. Each operation item (declare, check, index check,
// divisor check, read, assign, clear) gives exactly one result item with a
// status code; an error leaves the table unchanged. Items are handled one
// at a time: a single name comparator walks the name memory one entry per
// cycle and stops at the first match or, on a miss, after all live entries.
// The next item is taken once the result is in the output register, even
// if it has not been collected yet; while an earlier result still waits
// there, the item holds until it is taken.
// ---------------------------------------------------------------------------
module keyed_symbol_table (
  input  logic clk,
  input  logic rst,
  kst_in_if.sink    cmd,
  kst_out_if.source rsp
);

  kst_pkg::item_t     item;
  kst_pkg::srch_ctl_t sctl;
  kst_pkg::srch_sts_t sts;
  kst_pkg::cnt_t      count;
  kst_pkg::attr_t     attr_rdata;
  kst_pkg::attr_t     attr_wdata;
  kst_pkg::idx_t      attr_waddr;
  kst_pkg::res_t      res;
  kst_pkg::res_t      res_q;
  logic               attr_we;
  logic               idle;
  logic               cmd_fire;
  logic               out_free;
  logic               out_load;
  logic               rsp_valid;

  assign cmd.ready = idle;
  assign cmd_fire  = cmd.valid && idle;
  assign out_free  = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      item <= '{op:    cmd.op,
                name:  kst_pkg::pack_name(cmd.name_word_0, cmd.name_word_1,
                                          cmd.name_word_2, cmd.name_word_3),
                kind:  cmd.var_kind,
                size:  cmd.array_size,
                data:  cmd.data_value,
                index: cmd.array_index};
    end
  end

  // result register, frees the input side while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_q <= res;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = res_q.status;
  assign rsp.value_known = res_q.known;
  assign rsp.read_value  = res_q.value;

  kst_search u_search (
    .clk   (clk),
    .rst   (rst),
    .ctl   (sctl),
    .key   (item.name),
    .count (count),
    .sts   (sts)
  );

  kst_attr_store u_attr (
    .clk   (clk),
    .we    (attr_we),
    .waddr (attr_waddr),
    .wdata (attr_wdata),
    .raddr (sts.idx),
    .rdata (attr_rdata)
  );

  kst_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_fire   (cmd_fire),
    .out_free   (out_free),
    .item       (item),
    .sts        (sts),
    .attr       (attr_rdata),
    .idle       (idle),
    .sctl       (sctl),
    .count      (count),
    .attr_we    (attr_we),
    .attr_waddr (attr_waddr),
    .attr_wdata (attr_wdata),
    .out_load   (out_load),
    .res        (res)
  );

endmodule

FILE: rtl/kst_checker.sv
// ---------------------------------------------------------------------------
// kst_checker
// port-level checks on the keyed symbol table, attached by bind
// ---------------------------------------------------------------------------
`include "keyed_symbol_table_macros.svh"

module kst_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [2:0]                    rsp_status,
  input logic                          rsp_value_known,
  input logic [kst_pkg::DATA_W-1:0]    rsp_read_value
);

  logic status_ok;
  logic value_zero;

  assign status_ok  = (rsp_status == kst_pkg::ST_OK);
  assign value_zero = (rsp_read_value == '0);

  // one item at a time: no transfer on the cycle after one
  `KST_ASSERT(a_busy_after_cmd, cmd_valid && cmd_ready |=> !cmd_ready, "ready after transfer")

  `KST_ASSERT(a_rsp_held, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped")

  `KST_ASSERT(a_known_ok, rsp_valid && rsp_value_known |-> status_ok, "known with error")

  `KST_ASSERT_ALWAYS(a_unknown_zero, rsp_valid && !rsp_value_known |-> value_zero, "stray value")

endmodule

bind keyed_symbol_table kst_checker u_kst_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_value_known (rsp.value_known),
  .rsp_read_value  (rsp.read_value)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for keyed_symbol_table. Operation items go in through
// the command channel and each accepted transfer is run through a local
// model of the table. The model's result is queued, and each result transfer
// is compared field by field with the oldest queued result. Directed checks
// come first, then a fill of the whole table, a long output stall, and three
// randomised phases with different idling on each side.
// ---------------------------------------------------------------------------
module tb;
  import kst_pkg::*;

  localparam int SPARE_OP_LO = 9;
  localparam int SPARE_OP_HI = 15;
  localparam int POOL_SIZE   = 80;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;

  kst_in_if  cmd_if ();
  kst_out_if rsp_if ();

  keyed_symbol_table dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  // local copy of the table
  name_t             sym_name  [TABLE_DEPTH];
  logic              sym_const [TABLE_DEPTH];
  logic [SIZE_W-1:0] sym_size  [TABLE_DEPTH];
  logic [DATA_W-1:0] sym_cval  [TABLE_DEPTH];
  logic [DATA_W-1:0] sym_val   [TABLE_DEPTH];
  logic              sym_known [TABLE_DEPTH];
  int                sym_count;

  res_t  expected_results[$];
  name_t name_pool[POOL_SIZE];
  int    mismatches;
  int    send_idle_pct;
  int    recv_idle_pct;
  bit    hold_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // model of the table
  // ---------------------------------------------------------------------------
  function automatic int find_slot(name_t nm);
    for (int e = 0; e < sym_count; e++) begin
      if (sym_name[e] == nm) return e;
    end
    return -1;
  endfunction

  function automatic res_t predict_result(item_t it);
    res_t r;
    int   hit;
    int   idx;
    r.status = ST_OK;
    r.known  = 1'b0;
    r.value  = '0;
    hit = find_slot(it.name);
    idx = $signed(it.index);
    case (it.op)
      OP_DECL_VAR, OP_DECL_CONST: begin
        if (hit >= 0) begin
          r.status = ST_REDECLARED;
        end else if (sym_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          sym_name[sym_count] = it.name;
          if (it.op == OP_DECL_VAR) begin
            sym_const[sym_count] = 1'b0;
            sym_size[sym_count]  = it.size;
            sym_cval[sym_count]  = '0;
            sym_val[sym_count]   = '0;
            sym_known[sym_count] = 1'b0;
          end else begin
            sym_const[sym_count] = 1'b1;
            sym_size[sym_count]  = '0;
            sym_cval[sym_count]  = it.data;
            sym_val[sym_count]   = it.data;
            sym_known[sym_count] = 1'b1;
          end
          sym_count++;
        end
      end
      OP_CHECK: begin
        if (hit < 0) r.status = ST_UNDECLARED;
      end
      OP_INDEX, OP_INDEX_ANY: begin
        if (hit < 0) begin
          r.status = ST_UNDECLARED;
        end else if (sym_size[hit] == '0) begin
          r.status = ST_NOT_ARRAY;
        end else if (it.op == OP_INDEX && (idx < 0 || idx >= int'(sym_size[hit]))) begin
          r.status = ST_OUT_OF_RANGE;
        end
      end
      OP_DIVISOR: begin
        if (it.data == '0) r.status = ST_ZERO_DIVISOR;
      end
      OP_READ: begin
        if (hit >= 0) begin
          // a constant keeps its declared value whatever was assigned since
          if (sym_const[hit]) begin
            r.known = 1'b1;
            r.value = sym_cval[hit];
          end else if (sym_known[hit]) begin
            r.known = 1'b1;
            r.value = sym_val[hit];
          end
        end
      end
      OP_ASSIGN: begin
        if (hit < 0) begin
          r.status = ST_UNDECL_ASSIGN;
        end else begin
          sym_val[hit]   = it.data;
          sym_known[hit] = 1'b1;
        end
      end
      OP_CLEAR: sym_count = 0;
      default: ;
    endcase
    return r;
  endfunction

  function automatic void report_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  // results are checked before the command transfer of the same edge is modelled
  always @(posedge clk) begin
    item_t seen;
    res_t  want;
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with nothing expected, actual status %0h", $time,
                   rsp_if.status);
        end else begin
          want = expected_results.pop_front();
          report_field("status", want.status, rsp_if.status);
          report_field("value_known", want.known, rsp_if.value_known);
          report_field("read_value", want.value, rsp_if.read_value);
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        seen.op    = cmd_if.op;
        seen.name  = {cmd_if.name_word_3, cmd_if.name_word_2,
                      cmd_if.name_word_1, cmd_if.name_word_0};
        seen.kind  = cmd_if.var_kind;
        seen.size  = cmd_if.array_size;
        seen.data  = cmd_if.data_value;
        seen.index = cmd_if.array_index;
        expected_results.push_back(predict_result(seen));
      end
    end
  end

  // receiver, with an occasional long hold-off on request
  initial begin
    int  hold_left;
    logic nxt;
    hold_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        nxt = 1'b0;
      end else begin
        nxt = ($urandom_range(99) >= recv_idle_pct);
      end
      rsp_if.ready <= nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic name_t str_name(string s);
    name_t nm;
    nm = '0;
    for (int i = 0; i < s.len(); i++) nm[8*i +: 8] = s[i];
    return nm;
  endfunction

  function automatic name_t text_name(int len);
    name_t nm;
    int    r;
    nm = '0;
    for (int i = 0; i < len; i++) begin
      r = (i == 0) ? $urandom_range(25) : $urandom_range(36);
      if (r < 26) nm[8*i +: 8] = 8'(int'("a") + r);
      else if (r < 36) nm[8*i +: 8] = 8'(int'("0") + r - 26);
      else nm[8*i +: 8] = "_";
    end
    return nm;
  endfunction

  function automatic name_t fresh_name();
    name_t nm;
    int    r;
    r = $urandom_range(99);
    if (r < 50) begin
      nm = text_name($urandom_range(1, 31));
    end else if (r < 65) begin
      nm = text_name(32);
    end else if (r < 85) begin
      for (int i = 0; i < 8; i++) nm[32*i +: 32] = $urandom;
    end else begin
      // near miss: one bit away from a known name, padding bytes included
      nm = name_pool[$urandom_range(POOL_SIZE-1)];
      nm[$urandom_range(NAME_W-1)] ^= 1'b1;
    end
    return nm;
  endfunction

  function automatic name_t live_name();
    if (sym_count == 0) return fresh_name();
    return sym_name[$urandom_range(sym_count-1)];
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 30) return '0;
    if (r < 80) return SIZE_W'($urandom_range(1, 8));
    if (r < 95) return SIZE_W'($urandom_range(65535));
    return '1;
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    int r;
    r = $urandom_range(99);
    if (r < 12) return '0;
    if (r < 17) return 32'h8000_0000;
    if (r < 22) return 32'h7fff_ffff;
    if (r < 27) return '1;
    if (r < 32) return 32'd1;
    return $urandom;
  endfunction

  function automatic logic [DATA_W-1:0] pick_index(int unsigned s);
    int r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 30) return 32'(s) - 32'd1;
    if (r < 45) return 32'(s);
    if (r < 52) return '1;
    if (r < 57) return 32'h8000_0000;
    if (r < 62) return 32'h7fff_ffff;
    if (r < 80) return 32'($urandom_range(0, s + 1));
    return $urandom;
  endfunction

  function automatic item_t make_item(logic [OP_W-1:0] op, name_t nm, logic [KIND_W-1:0] kind,
                                      logic [SIZE_W-1:0] size, logic [DATA_W-1:0] data,
                                      logic [DATA_W-1:0] index);
    item_t it;
    it.op    = op;
    it.name  = nm;
    it.kind  = kind;
    it.size  = size;
    it.data  = data;
    it.index = index;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      cmd_if.valid <= 1'b0;
    end
    @(negedge clk);
    cmd_if.valid       <= 1'b1;
    cmd_if.op          <= it.op;
    cmd_if.name_word_0 <= it.name[63:0];
    cmd_if.name_word_1 <= it.name[127:64];
    cmd_if.name_word_2 <= it.name[191:128];
    cmd_if.name_word_3 <= it.name[255:192];
    cmd_if.var_kind    <= it.kind;
    cmd_if.array_size  <= it.size;
    cmd_if.data_value  <= it.data;
    cmd_if.array_index <= it.index;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic refill_pool();
    for (int i = 0; i < POOL_SIZE; i++) name_pool[i] = fresh_name();
  endtask

  task automatic random_item(input int clear_permille);
    item_t it;
    int    r;
    int    hit;
    it.kind = KIND_W'($urandom_range(7));
    it.size = pick_size();
    it.data = pick_data();
    r = $urandom_range(99);
    if ($urandom_range(999) < clear_permille) it.op = OP_CLEAR;
    else if (r < 20) it.op = OP_DECL_VAR;
    else if (r < 30) it.op = OP_DECL_CONST;
    else if (r < 37) it.op = OP_CHECK;
    else if (r < 47) it.op = OP_INDEX;
    else if (r < 53) it.op = OP_INDEX_ANY;
    else if (r < 59) it.op = OP_DIVISOR;
    else if (r < 76) it.op = OP_READ;
    else if (r < 96) it.op = OP_ASSIGN;
    else it.op = OP_W'($urandom_range(SPARE_OP_LO, SPARE_OP_HI));
    r = $urandom_range(99);
    if (it.op == OP_DECL_VAR || it.op == OP_DECL_CONST) begin
      if (r < 55) it.name = name_pool[$urandom_range(POOL_SIZE-1)];
      else if (r < 70) it.name = live_name();
      else it.name = fresh_name();
    end else begin
      if (r < 70) it.name = live_name();
      else if (r < 85) it.name = name_pool[$urandom_range(POOL_SIZE-1)];
      else it.name = fresh_name();
    end
    // aim the index at the declared length where the name is already known
    hit = find_slot(it.name);
    it.index = pick_index((hit >= 0) ? sym_size[hit] : it.size);
    send_item(it);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_empty_table();
    name_t nm;
    nm = str_name("alpha");
    send_item(make_item(OP_CLEAR, nm, '1, '1, '1, '1));
    send_item(make_item(OP_READ, nm, '0, '0, '0, '0));
    send_item(make_item(OP_CHECK, nm, '0, '0, '0, '0));
    send_item(make_item(OP_ASSIGN, nm, '0, '0, 32'd7, '0));
    send_item(make_item(OP_INDEX, nm, '0, '0, '0, '0));
  endtask

  task automatic test_declarations();
    name_t a;
    name_t pi;
    a  = str_name("alpha");
    pi = str_name("pi");
    send_item(make_item(OP_DECL_VAR, a, 3'd7, '0, '0, '0));
    send_item(make_item(OP_DECL_VAR, a, 3'd1, 16'd4, '0, '0));
    send_item(make_item(OP_DECL_CONST, pi, 3'd6, 16'd9, 32'h7fff_ffff, '0));
    send_item(make_item(OP_DECL_CONST, a, '0, '0, 32'd3, '0));
    send_item(make_item(OP_READ, a, '0, '0, '0, '0));
    send_item(make_item(OP_ASSIGN, a, '0, '0, '1, '0));
    send_item(make_item(OP_READ, a, '0, '0, '0, '0));
    // assigning to a constant must not change what it reads back
    send_item(make_item(OP_ASSIGN, pi, '0, '0, 32'd5, '0));
    send_item(make_item(OP_READ, pi, '0, '0, '0, '0));
  endtask

  task automatic test_arrays();
    name_t arr;
    arr = str_name("arr");
    send_item(make_item(OP_INDEX, str_name("alpha"), '0, '0, '0, '0));
    send_item(make_item(OP_DECL_VAR, arr, 3'd5, '1, '0, '0));
    send_item(make_item(OP_INDEX, arr, '0, '0, '0, 32'h0000_fffe));
    send_item(make_item(OP_INDEX, arr, '0, '0, '0, 32'h0000_ffff));
    send_item(make_item(OP_INDEX, arr, '0, '0, '0, '1));
    send_item(make_item(OP_INDEX, arr, '0, '0, '0, 32'h8000_0000));
    send_item(make_item(OP_INDEX_ANY, arr, '0, '0, '0, 32'h8000_0000));
    send_item(make_item(OP_INDEX_ANY, str_name("pi"), '0, '0, '0, '0));
  endtask

  task automatic test_divisor_and_spare();
    send_item(make_item(OP_DIVISOR, fresh_name(), '0, '0, '0, '0));
    send_item(make_item(OP_DIVISOR, fresh_name(), '0, '0, 32'h8000_0000, '0));
    send_item(make_item(OP_W'(SPARE_OP_LO), str_name("alpha"), '1, '1, '1, '1));
    send_item(make_item(OP_W'(SPARE_OP_HI), '1, '1, '1, '1, '1));
  endtask

  task automatic test_name_compare();
    name_t ab;
    name_t ab_tail;
    ab = str_name("ab");
    ab_tail = ab;
    // same visible text, but a byte after the first zero differs
    ab_tail[8*5 +: 8] = "x";
    send_item(make_item(OP_DECL_VAR, ab, '0, '0, '0, '0));
    send_item(make_item(OP_DECL_VAR, ab_tail, '0, 16'd2, '0, '0));
    send_item(make_item(OP_CHECK, ab | (name_t'(1) << (NAME_W-1)), '0, '0, '0, '0));
  endtask

  task automatic test_fill_table();
    name_t nm;
    send_idle_pct = 10;
    recv_idle_pct = 10;
    send_item(make_item(OP_CLEAR, '0, '0, '0, '0, '0));
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      nm = fresh_name();
      nm[NAME_W-8 +: 8] = 8'(i);
      send_item(make_item(($urandom_range(3) == 0) ? OP_DECL_CONST : OP_DECL_VAR, nm,
                          KIND_W'($urandom_range(7)), pick_size(), pick_data(), '0));
    end
    wait_drain();
    send_item(make_item(OP_DECL_VAR, fresh_name(), '0, '0, '0, '0));
    // a duplicate is reported as such even when the table is full
    send_item(make_item(OP_DECL_CONST, sym_name[TABLE_DEPTH-1], '0, '0, '0, '0));
    send_item(make_item(OP_DECL_CONST, fresh_name(), '0, '0, 32'd1, '0));
    for (int i = 0; i < 40; i++) random_item(0);
    wait_drain();
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++) random_item(0);
    wait_drain();
  endtask

  task automatic test_random(input int count, input int send_pct, input int recv_pct,
                             input int clear_permille);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    refill_pool();
    for (int i = 0; i < count; i++) random_item(clear_permille);
    wait_drain();
  endtask

  initial begin
    rst = 1'b1;
    hold_req = 1'b0;
    mismatches = 0;
    sym_count = 0;
    send_idle_pct = 20;
    recv_idle_pct = 20;
    cmd_if.valid       = 1'b0;
    cmd_if.op          = '0;
    cmd_if.name_word_0 = '0;
    cmd_if.name_word_1 = '0;
    cmd_if.name_word_2 = '0;
    cmd_if.name_word_3 = '0;
    cmd_if.var_kind    = '0;
    cmd_if.array_size  = '0;
    cmd_if.data_value  = '0;
    cmd_if.array_index = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    refill_pool();

    test_empty_table();
    test_declarations();
    test_arrays();
    test_divisor_and_spare();
    test_name_compare();
    test_fill_table();
    test_output_stall();
    test_random(600, 30, 58, 20);
    test_random(600, 58, 30, 20);
    test_random(400, 0, 0, 4);

    wait_drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
